// ===== rtl/core/pgcm_pkg.sv =====
// Shared constants, register codes and inter-stage types for the gradient color map.
package pgcm_pkg;

  // Palette size and iteration field limits
  localparam int MAX_COLORS   = 4;
  localparam int ITER_BITS    = 16;
  localparam int PALETTE_REGS = 4;

  // Field widths
  localparam int WHOLE_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int CH_W       = 8;
  localparam int CHANNELS   = 3;
  localparam int COLOR_W    = CH_W * CHANNELS;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  // Derived widths: segment index, fixed-point iteration value, scaled position
  localparam int SEG_W  = $clog2(MAX_COLORS);
  localparam int J_W    = WHOLE_W + FRAC_W;
  localparam int N_W    = J_W + SEG_W;
  localparam int Q_W    = FRAC_W + SEG_W;
  localparam int PROD_W = CH_W + FRAC_W;

  // Accept edge to result strobe: input stage, remainder steps, multiply stage,
  // quotient steps, segment stage, product stage, output stage
  localparam int PIPE_DEPTH = WHOLE_W + Q_W + 5;

  localparam logic [WHOLE_W-1:0] WHOLE_MASK =
    (ITER_BITS >= WHOLE_W) ? {WHOLE_W{1'b1}} : WHOLE_W'((1 << ITER_BITS) - 1);

  // Register reset values
  localparam logic [WHOLE_W-1:0] MAX_ITER_RST    = WHOLE_W'(256);
  localparam logic [WHOLE_W-1:0] CYCLE_LEN_RST   = '0;
  localparam logic [CNT_W-1:0]   COLOR_COUNT_RST = CNT_W'(2);
  localparam logic [COLOR_W-1:0] PALETTE_1_RST   = {COLOR_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER,
    REG_CYCLE_LEN,
    REG_COLOR_COUNT,
    REG_PALETTE_0,
    REG_PALETTE_1,
    REG_PALETTE_2,
    REG_PALETTE_3
  } cfg_reg_t;

  // Decoded configuration seen by the datapath
  typedef struct packed {
    logic                                cycling;
    logic [WHOLE_W-1:0]                  divisor;
    logic [SEG_W-1:0]                    cols_m1;
    logic [MAX_COLORS-1:0][COLOR_W-1:0]  palette;
  } cfg_t;

  // Remainder pipeline result
  typedef struct packed {
    logic               vld;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [WHOLE_W-1:0] rem;
    logic               ovf;
  } mod_res_t;

  // Segment and blend weight for the mixer
  typedef struct packed {
    logic              vld;
    logic [SEG_W-1:0]  seg;
    logic [FRAC_W-1:0] wgt;
  } mix_req_t;

endpackage

// ===== rtl/core/pgcm_cfg.sv =====
// Configuration register file and decode of divisor, cycling mode and color count.
module pgcm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pgcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output pgcm_pkg::cfg_t                 cfg
);
  import pgcm_pkg::*;

  localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_COLORS);
  localparam logic [CNT_W:0] MIN_CNT = (CNT_W + 1)'(2);

  logic [WHOLE_W-1:0]   max_iter_r;
  logic [WHOLE_W-1:0]   cycle_len_r;
  logic [CNT_W-1:0]     color_count_r;
  logic [COLOR_W-1:0]   palette_r [MAX_COLORS];
  logic [CFG_IDX_W-1:0] slot;
  logic [CNT_W:0]       cnt_clamp;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign slot      = cfg_index - CFG_IDX_W'(REG_PALETTE_0);

  // Hold the registers, update on a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r    <= MAX_ITER_RST;
      cycle_len_r   <= CYCLE_LEN_RST;
      color_count_r <= COLOR_COUNT_RST;
      for (int i = 0; i < MAX_COLORS; i++) begin
        palette_r[i] <= (i == 1) ? PALETTE_1_RST : '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index)) inside
        REG_MAX_ITER:    max_iter_r    <= cfg_data[WHOLE_W-1:0];
        REG_CYCLE_LEN:   cycle_len_r   <= cfg_data[WHOLE_W-1:0];
        REG_COLOR_COUNT: color_count_r <= cfg_data[CNT_W-1:0];
        REG_PALETTE_0, REG_PALETTE_1, REG_PALETTE_2, REG_PALETTE_3: begin
          // drop writes to slots the palette does not have
          if (int'(slot) < MAX_COLORS) begin
            palette_r[slot[SEG_W-1:0]] <= cfg_data[COLOR_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Clamp the color count into the supported range
  always_comb begin
    if ({1'b0, color_count_r} < MIN_CNT) begin
      cnt_clamp = MIN_CNT;
    end else if ({1'b0, color_count_r} > MAX_CNT) begin
      cnt_clamp = MAX_CNT;
    end else begin
      cnt_clamp = {1'b0, color_count_r};
    end
  end

  // Decode divisor and mode; a zero limit acts as one
  always_comb begin
    cfg.cycling = (cycle_len_r >= WHOLE_W'(2));
    if (cfg.cycling) begin
      cfg.divisor = cycle_len_r - WHOLE_W'(1);
    end else if (max_iter_r == '0) begin
      cfg.divisor = WHOLE_W'(1);
    end else begin
      cfg.divisor = max_iter_r;
    end
    cfg.cols_m1 = SEG_W'(cnt_clamp - (CNT_W + 1)'(1));
    for (int i = 0; i < MAX_COLORS; i++) begin
      cfg.palette[i] = palette_r[i];
    end
  end

endmodule

// ===== rtl/core/pgcm_mod.sv =====
// Bit-per-stage remainder pipeline: whole part modulo the divisor, plus overflow flag.
module pgcm_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [pgcm_pkg::WHOLE_W-1:0] in_whole,
  input  logic [pgcm_pkg::FRAC_W-1:0]  in_frac,
  input  pgcm_pkg::cfg_t              cfg,
  output pgcm_pkg::mod_res_t          res
);
  import pgcm_pkg::*;

  localparam int STEPS = WHOLE_W;

  logic               vld_r   [0:STEPS];
  logic               ovf_r   [0:STEPS];
  logic [WHOLE_W-1:0] whole_r [0:STEPS];
  logic [WHOLE_W-1:0] rem_r   [0:STEPS];
  logic [FRAC_W-1:0]  frac_r  [0:STEPS];

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    whole_r[0] <= in_whole & WHOLE_MASK;
    frac_r[0]  <= in_frac;
    rem_r[0]   <= '0;
    ovf_r[0]   <= 1'b0;
  end

  // One restoring step per stage, most significant bit first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [WHOLE_W:0] shl;
    logic [WHOLE_W:0] diff;
    logic             ge;
    logic [WHOLE_W-1:0] rem_nxt;

    assign shl     = {rem_r[k], whole_r[k][WHOLE_W-1-k]};
    assign diff    = shl - {1'b0, cfg.divisor};
    assign ge      = (shl >= {1'b0, cfg.divisor});
    assign rem_nxt = ge ? diff[WHOLE_W-1:0] : shl[WHOLE_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    // Advance payload; any nonzero quotient bit marks whole >= divisor
    always_ff @(posedge clk) begin
      rem_r[k+1]   <= rem_nxt;
      whole_r[k+1] <= whole_r[k];
      frac_r[k+1]  <= frac_r[k];
      ovf_r[k+1]   <= ovf_r[k] | ge;
    end
  end

  assign res.vld   = vld_r[STEPS];
  assign res.whole = whole_r[STEPS];
  assign res.frac  = frac_r[STEPS];
  assign res.rem   = rem_r[STEPS];
  assign res.ovf   = ovf_r[STEPS];

endmodule

// ===== rtl/core/pgcm_pos.sv =====
// Scaled position: iteration times segment count, divided bit by bit, then clamped.
module pgcm_pos (
  input  logic               clk,
  input  logic               rst_n,
  input  pgcm_pkg::mod_res_t src,
  input  pgcm_pkg::cfg_t     cfg,
  output pgcm_pkg::mix_req_t req
);
  import pgcm_pkg::*;

  logic [J_W-1:0]     j;
  logic [N_W-1:0]     n_prod;
  logic               vld_r   [0:Q_W];
  logic               clamp_r [0:Q_W];
  logic [WHOLE_W-1:0] rem_r   [0:Q_W];
  logic [Q_W-1:0]     nlo_r   [0:Q_W];
  logic [Q_W-1:0]     quo_r   [0:Q_W];
  mix_req_t           req_r;
  mix_req_t           req_nxt;

  // Pick the wrapped or raw position and scale by the segment count
  assign j      = cfg.cycling ? {src.rem, src.frac} : {src.whole, src.frac};
  assign n_prod = N_W'(j) * N_W'(cfg.cols_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= src.vld;
    end
  end

  // Upper bits start below the divisor, so only Q_W quotient bits remain
  always_ff @(posedge clk) begin
    rem_r[0]   <= n_prod[N_W-1:Q_W];
    nlo_r[0]   <= n_prod[Q_W-1:0];
    quo_r[0]   <= '0;
    clamp_r[0] <= src.ovf & ~cfg.cycling;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [WHOLE_W:0]   shl;
    logic [WHOLE_W:0]   diff;
    logic               ge;
    logic [WHOLE_W-1:0] rem_nxt;

    assign shl     = {rem_r[k], nlo_r[k][Q_W-1-k]};
    assign diff    = shl - {1'b0, cfg.divisor};
    assign ge      = (shl >= {1'b0, cfg.divisor});
    assign rem_nxt = ge ? diff[WHOLE_W-1:0] : shl[WHOLE_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    // Shift in one quotient bit per stage
    always_ff @(posedge clk) begin
      rem_r[k+1]   <= rem_nxt;
      nlo_r[k+1]   <= nlo_r[k];
      quo_r[k+1]   <= {quo_r[k][Q_W-2:0], ge};
      clamp_r[k+1] <= clamp_r[k];
    end
  end

  // Split into segment and weight; past the top, hold just below one
  always_comb begin
    req_nxt.vld = vld_r[Q_W];
    if (clamp_r[Q_W]) begin
      req_nxt.seg = cfg.cols_m1 - SEG_W'(1);
      req_nxt.wgt = '1;
    end else begin
      req_nxt.seg = quo_r[Q_W][Q_W-1:FRAC_W];
      req_nxt.wgt = quo_r[Q_W][FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else begin
      req_r.vld <= req_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    req_r.seg <= req_nxt.seg;
    req_r.wgt <= req_nxt.wgt;
  end

  assign req = req_r;

endmodule

// ===== rtl/core/pgcm_mix.sv =====
// Per-channel linear blend between adjacent palette colors.
module pgcm_mix (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pgcm_pkg::mix_req_t       req,
  input  pgcm_pkg::cfg_t           cfg,
  output logic                     out_vld,
  output logic [pgcm_pkg::CH_W-1:0] out_red,
  output logic [pgcm_pkg::CH_W-1:0] out_green,
  output logic [pgcm_pkg::CH_W-1:0] out_blue
);
  import pgcm_pkg::*;

  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  logic [SEG_W-1:0]   seg_hi;
  logic [COLOR_W-1:0] lo_color;
  logic [COLOR_W-1:0] hi_color;
  logic [PROD_W-1:0]  inv_w;
  logic [PROD_W-1:0]  wgt_ext;
  logic [PROD_W-1:0]  prod_lo_nxt [CHANNELS];
  logic [PROD_W-1:0]  prod_hi_nxt [CHANNELS];
  logic [PROD_W-1:0]  prod_lo_r   [CHANNELS];
  logic [PROD_W-1:0]  prod_hi_r   [CHANNELS];
  logic [CH_W-1:0]    chan_nxt    [CHANNELS];
  logic [CH_W-1:0]    chan_r      [CHANNELS];
  logic               prod_vld_r;
  logic               out_vld_r;

  // Fetch the two end colors of the segment
  assign seg_hi   = req.seg + SEG_W'(1);
  assign lo_color = cfg.palette[req.seg];
  assign hi_color = cfg.palette[seg_hi];
  assign wgt_ext  = PROD_W'(req.wgt);
  assign inv_w    = PROD_W'(1 << FRAC_W) - wgt_ext;

  // Weight each end; products fit PROD_W bits
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod_lo_nxt[ch] = PROD_W'(lo_color[ch*CH_W +: CH_W]) * inv_w;
      prod_hi_nxt[ch] = PROD_W'(hi_color[ch*CH_W +: CH_W]) * wgt_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      prod_vld_r <= req.vld;
      out_vld_r  <= prod_vld_r;
    end
  end

  // Sum and drop the fraction
  always_comb begin
    logic [PROD_W:0] sum;
    sum = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum          = {1'b0, prod_lo_r[ch]} + {1'b0, prod_hi_r[ch]};
      chan_nxt[ch] = sum[PROD_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod_lo_r[ch] <= prod_lo_nxt[ch];
      prod_hi_r[ch] <= prod_hi_nxt[ch];
      chan_r[ch]    <= chan_nxt[ch];
    end
  end

  assign out_vld   = out_vld_r;
  assign out_red   = chan_r[CH_RED];
  assign out_green = chan_r[CH_GREEN];
  assign out_blue  = chan_r[CH_BLUE];

endmodule

// ===== rtl/core/palette_gradient_color_map.sv =====
// Top level of the gradient palette color map: ports, pipeline wiring and checks.
//
// Takes one iteration value (whole part plus 8-bit fraction) per clock and
// returns its RGB color, strobed by out_valid for one cycle; busy stays low,
// so a new transaction may be started every cycle, and results come out in
// order with no way for the receiver to hold them off. The pipeline is made
// up mostly of the two restoring dividers, one bit per stage: 16 stages for
// the whole part modulo the period (or the overflow test against the limit)
// and 10 stages for the scaled position, plus five stages of input, multiply,
// segment select and blend. Configuration writes are always ready and apply
// to transactions started after them; write only while no transaction is in
// flight.
module palette_gradient_color_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [pgcm_pkg::WHOLE_W-1:0]    in_iteration_whole,
  input  logic [pgcm_pkg::FRAC_W-1:0]     in_iteration_fraction,
  output logic                            out_valid,
  output logic [pgcm_pkg::CH_W-1:0]       out_red,
  output logic [pgcm_pkg::CH_W-1:0]       out_green,
  output logic [pgcm_pkg::CH_W-1:0]       out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pgcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pgcm_pkg::*;

  cfg_t     cfg;
  mod_res_t mod_res;
  mix_req_t mix_req;
  logic     in_accept;

  // Fully pipelined: never stall the source
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  pgcm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgcm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_accept),
    .in_whole (in_iteration_whole),
    .in_frac  (in_iteration_fraction),
    .cfg      (cfg),
    .res      (mod_res)
  );

  pgcm_pos u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .src   (mod_res),
    .cfg   (cfg),
    .req   (mix_req)
  );

  pgcm_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mix_req),
    .cfg       (cfg),
    .out_vld   (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  // Every accepted transaction yields a strobe after the fixed latency
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##PIPE_DEPTH out_valid)
    else $error("accepted transaction produced no result at pipeline latency");

  // No strobe without a matching accepted transaction
  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, PIPE_DEPTH))
    else $error("result strobe without a matching accepted transaction");

  // The selected segment always has a color above it in the palette
  a_segment_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mix_req.vld |-> (mix_req.seg < cfg.cols_m1))
    else $error("segment index beyond the last palette pair");

endmodule

// ===== verif/pgcm_color_checker.sv =====
// Checker for the gradient color map: tracks settings, predicts each color, compares results.
`timescale 1ns / 1ps

module pgcm_color_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [pgcm_pkg::WHOLE_W-1:0]    in_iteration_whole,
  input  logic [pgcm_pkg::FRAC_W-1:0]     in_iteration_fraction,
  input  logic                            out_valid,
  input  logic [pgcm_pkg::CH_W-1:0]       out_red,
  input  logic [pgcm_pkg::CH_W-1:0]       out_green,
  input  logic [pgcm_pkg::CH_W-1:0]       out_blue,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pgcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              results_pending,
  output int                              mismatch_count
);
  import pgcm_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Shadow copy of the register file
  logic [WHOLE_W-1:0] limit_reg;
  logic [WHOLE_W-1:0] period_reg;
  logic [CNT_W-1:0]   count_reg;
  logic [COLOR_W-1:0] pal_reg [MAX_COLORS];

  rgb_t expected_colors[$];
  int   fail_count = 0;

  assign mismatch_count = fail_count;

  // Print one line and count the failure
  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Weighted mix of two channel values, truncated
  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b,
                                            input logic [FRAC_W-1:0] wgt);
    logic [PROD_W:0] acc;
    acc = a * (9'd256 - wgt) + b * wgt;
    return acc[PROD_W-1:FRAC_W];
  endfunction

  // Color expected for one iteration value under the current settings
  function automatic rgb_t color_of(input logic [WHOLE_W-1:0] whole,
                                    input logic [FRAC_W-1:0] frac);
    logic [J_W-1:0]     iter_fx;
    logic [J_W-1:0]     dvs;
    logic [SEG_W:0]     cols;
    logic [SEG_W-1:0]   span;
    logic [N_W-1:0]     pos;
    logic [SEG_W-1:0]   seg;
    logic [FRAC_W-1:0]  wgt;
    logic [COLOR_W-1:0] lo;
    logic [COLOR_W-1:0] hi;
    rgb_t               color;
    iter_fx = {whole & WHOLE_MASK, frac};
    // clamp the color count into the supported range
    if (count_reg < CNT_W'(2))
      cols = (SEG_W + 1)'(2);
    else if (count_reg > CNT_W'(MAX_COLORS))
      cols = (SEG_W + 1)'(MAX_COLORS);
    else
      cols = (SEG_W + 1)'(count_reg);
    span = SEG_W'(cols - (SEG_W + 1)'(1));
    if (period_reg >= WHOLE_W'(2)) begin
      // cycling: wrap the position over the period
      dvs = J_W'(period_reg) - J_W'(1);
      iter_fx = iter_fx % (dvs << FRAC_W);
      pos = (N_W'(iter_fx) * N_W'(span)) / N_W'(dvs);
    end else begin
      // linear: a zero limit counts as one, clamp at the top just below one
      dvs = (limit_reg == '0) ? J_W'(1) : J_W'(limit_reg);
      if (iter_fx >= (dvs << FRAC_W))
        pos = (N_W'(span) << FRAC_W) - N_W'(1);
      else
        pos = (N_W'(iter_fx) * N_W'(span)) / N_W'(dvs);
    end
    seg = pos[FRAC_W +: SEG_W];
    wgt = pos[FRAC_W-1:0];
    if ((pos >> FRAC_W) >= N_W'(span)) begin
      seg = span - SEG_W'(1);
      wgt = '1;
    end
    lo = pal_reg[seg];
    hi = pal_reg[seg + SEG_W'(1)];
    color.red   = blend(lo[2*CH_W +: CH_W], hi[2*CH_W +: CH_W], wgt);
    color.green = blend(lo[CH_W +: CH_W], hi[CH_W +: CH_W], wgt);
    color.blue  = blend(lo[0 +: CH_W], hi[0 +: CH_W], wgt);
    return color;
  endfunction

  // Follow writes, queue predictions, compare results in order
  always @(posedge clk) begin : track
    rgb_t oldest;
    if (!rst_n) begin
      limit_reg  <= MAX_ITER_RST;
      period_reg <= CYCLE_LEN_RST;
      count_reg  <= COLOR_COUNT_RST;
      for (int i = 0; i < MAX_COLORS; i++)
        pal_reg[i] <= (i == 1) ? PALETTE_1_RST : '0;
      expected_colors.delete();
      results_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAX_ITER:    limit_reg  <= cfg_data[WHOLE_W-1:0];
          REG_CYCLE_LEN:   period_reg <= cfg_data[WHOLE_W-1:0];
          REG_COLOR_COUNT: count_reg  <= cfg_data[CNT_W-1:0];
          REG_PALETTE_0:   pal_reg[0] <= cfg_data;
          REG_PALETTE_1:   pal_reg[1] <= cfg_data;
          REG_PALETTE_2:   pal_reg[2] <= cfg_data;
          REG_PALETTE_3:   pal_reg[3] <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_colors.push_back(color_of(in_iteration_whole, in_iteration_fraction));
      if (out_valid) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("result %02h%02h%02h with no transaction pending",
                                    out_red, out_green, out_blue));
        end else begin
          oldest = expected_colors.pop_front();
          if (out_red !== oldest.red)
            report_mismatch($sformatf("red got %02h expected %02h", out_red, oldest.red));
          if (out_green !== oldest.green)
            report_mismatch($sformatf("green got %02h expected %02h",
                                      out_green, oldest.green));
          if (out_blue !== oldest.blue)
            report_mismatch($sformatf("blue got %02h expected %02h", out_blue, oldest.blue));
        end
      end
      results_pending <= expected_colors.size();
    end
  end

endmodule

// ===== verif/tb_palette_gradient_color_map.sv =====
// Testbench top for the gradient color map: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_palette_gradient_color_map;
  import pgcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 36;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [WHOLE_W-1:0]    in_iteration_whole = '0;
  logic [FRAC_W-1:0]     in_iteration_fraction = '0;
  logic                  out_valid;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int results_pending;
  int mismatch_count;
  int stall_cycles = 0;
  int burst_left = 0;

  // Current limit and period, used only to aim the random iteration values
  int shp_max = 256;
  int shp_cyc = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  palette_gradient_color_map DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_iteration_whole    (in_iteration_whole),
    .in_iteration_fraction (in_iteration_fraction),
    .out_valid             (out_valid),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  pgcm_color_checker color_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_iteration_whole    (in_iteration_whole),
    .in_iteration_fraction (in_iteration_fraction),
    .out_valid             (out_valid),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .results_pending       (results_pending),
    .mismatch_count        (mismatch_count)
  );

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Send one pixel; open a new burst after a random gap when the last one ran out
  task automatic send_pixel(input logic [WHOLE_W-1:0] whole, input logic [FRAC_W-1:0] frac);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    start                 <= 1'b1;
    in_iteration_whole    <= whole;
    in_iteration_fraction <= frac;
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  // Hold the sender until every queued color has come back
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // One register write transaction; valid is left high for the next one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain, then rewrite every register
  task automatic program_settings(input int max_iter, input int cyc_len, input int cnt,
                                  input logic [COLOR_W-1:0] p0, input logic [COLOR_W-1:0] p1,
                                  input logic [COLOR_W-1:0] p2, input logic [COLOR_W-1:0] p3,
                                  input logic poke_unused);
    drain_pipeline();
    write_reg(REG_MAX_ITER, CFG_DATA_W'(max_iter));
    write_reg(REG_CYCLE_LEN, CFG_DATA_W'(cyc_len));
    write_reg(REG_COLOR_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_PALETTE_0, p0);
    write_reg(REG_PALETTE_1, p1);
    write_reg(REG_PALETTE_2, p2);
    write_reg(REG_PALETTE_3, p3);
    if (poke_unused)
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    shp_max = max_iter & 16'hFFFF;
    shp_cyc = cyc_len & 16'hFFFF;
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // Random settings with the extremes mixed in
  task automatic randomize_settings();
    int max_iter;
    int cyc_len;
    int cnt;
    case ($urandom_range(0, 5))
      0:       max_iter = 0;
      1:       max_iter = 1;
      2:       max_iter = 65535;
      3:       max_iter = $urandom_range(2, 64);
      default: max_iter = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 7))
      0:       cyc_len = 0;
      1:       cyc_len = 1;
      2:       cyc_len = 2;
      3:       cyc_len = 65535;
      4, 5:    cyc_len = $urandom_range(3, 300);
      default: cyc_len = $urandom_range(0, 65535);
    endcase
    cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
    program_settings(max_iter, cyc_len, cnt, pick_color(), pick_color(), pick_color(),
                     pick_color(), $urandom_range(0, 2) == 0);
  endtask

  // Whole part aimed around the active limit or period, sometimes anywhere
  function automatic logic [WHOLE_W-1:0] pick_whole();
    int lim;
    lim = (shp_cyc >= 2) ? shp_cyc - 1 : ((shp_max == 0) ? 1 : shp_max);
    case ($urandom_range(0, 7))
      0, 1:    return WHOLE_W'($urandom_range(0, 65535));
      2:       return WHOLE_W'(lim - 1);
      3:       return WHOLE_W'(lim);
      default: return WHOLE_W'($urandom_range(0, (2 * lim > 65535) ? 65535 : 2 * lim));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: ends of the ramp, clamp at the top, largest input
    send_pixel(16'd0, 8'd0);
    send_pixel(16'd0, 8'd255);
    send_pixel(16'd128, 8'd128);
    send_pixel(16'd255, 8'd255);
    send_pixel(16'd256, 8'd0);
    send_pixel(16'd65535, 8'd255);
    send_pixel(16'd1, 8'd1);

    // zero limit counts as one, color count zero counts as two, period one is linear
    program_settings(0, 1, 0, 24'h123456, 24'hFEDCBA, 24'h00FF00, 24'hFF00FF, 1'b0);
    send_pixel(16'd0, 8'd0);
    send_pixel(16'd0, 8'd200);
    send_pixel(16'd1, 8'd0);
    send_pixel(16'd3, 8'd7);

    // shortest period, oversized color count, write to an unmapped index
    program_settings(256, 2, 7, 24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 1'b1);
    send_pixel(16'd0, 8'd0);
    send_pixel(16'd0, 8'd255);
    send_pixel(16'd1, 8'd0);
    send_pixel(16'd40000, 8'd128);

    // longest period with three colors
    program_settings(65535, 65535, 3, 24'h0080FF, 24'hFF8000, 24'h7F7F7F, 24'h010203, 1'b0);
    send_pixel(16'd65533, 8'd255);
    send_pixel(16'd65534, 8'd0);
    send_pixel(16'd65535, 8'd255);
    send_pixel(16'd100, 8'd0);

    // largest limit, four colors, linear
    program_settings(65535, 0, 4, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0);
    send_pixel(16'd65534, 8'd255);
    send_pixel(16'd65535, 8'd0);
    send_pixel(16'd0, 8'd1);

    // random settings, each with a run of random pixels
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomize_settings();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && ph % 4 == 1)
          drain_pipeline();
        send_pixel(pick_whole(), FRAC_W'($urandom_range(0, 255)));
      end
    end

    // wait out the pipeline, then watch for stray results
    drain_pipeline();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pgcm_pkg.sv
rtl/core/pgcm_cfg.sv
rtl/core/pgcm_mod.sv
rtl/core/pgcm_pos.sv
rtl/core/pgcm_mix.sv
rtl/core/palette_gradient_color_map.sv
verif/pgcm_color_checker.sv
verif/tb_palette_gradient_color_map.sv
